// ===== rtl/three_class_server_scheduler_core_assert.svh =====
`ifndef THREE_CLASS_SERVER_SCHEDULER_CORE_ASSERT_SVH
`define THREE_CLASS_SERVER_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define SCQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/scq_pkg.sv =====
package scq_pkg;

  localparam int MODE_W     = 2;
  localparam int CLASS_W    = 2;
  localparam int SRV_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int STREAK_W   = 2;
  localparam int THR_W      = 5;
  localparam int MASK_W     = 4;
  localparam int CAP_W      = 3;
  localparam int NUM_CLASSES  = 3;
  localparam int SERVER_SLOTS = 4;

  localparam logic [STREAK_W-1:0] STREAK_RST   = 2'd3;
  localparam logic [THR_W-1:0]    THR_RST      = 5'd5;
  localparam logic [MASK_W-1:0]   MASK_RST     = 4'd3;
  localparam logic [CAP_W-1:0]    CAP_RST      = 3'd2;

  localparam logic [CLASS_W-1:0] CLS_NORMAL   = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_SERIOUS  = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_CRITICAL = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_INVALID  = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ARRIVAL  = 2'd0,
    MODE_REQUEST  = 2'd1,
    MODE_COMPLETE = 2'd2,
    MODE_TICK     = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2,
    ST_HELD = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STREAK_LIMIT = 2'd0,
    REG_AGING_THR    = 2'd1,
    REG_SENIOR_MASK  = 2'd2,
    REG_SENIOR_CAP   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

endpackage

// ===== rtl/scq_in_if.sv =====
interface scq_in_if;
  logic                          valid;
  logic                          ready;
  logic [scq_pkg::MODE_W-1:0]    mode;
  logic [scq_pkg::CLASS_W-1:0]   arrival_class;
  logic [scq_pkg::SRV_W-1:0]     server_index;

  modport source (output valid, mode, arrival_class, server_index, input ready);
  modport sink (input valid, mode, arrival_class, server_index, output ready);
endinterface

// ===== rtl/scq_out_if.sv =====
interface scq_out_if #(
  parameter int ID_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [scq_pkg::STATUS_W-1:0]  status;
  logic [ID_BITS-1:0]            item_id;
  logic [scq_pkg::CLASS_W-1:0]   item_class;
  logic [scq_pkg::TOTAL_W-1:0]   waiting_total;

  modport source (output valid, status, item_id, item_class, waiting_total, input ready);
  modport sink (input valid, status, item_id, item_class, waiting_total, output ready);
endinterface

// ===== rtl/scq_cfg_if.sv =====
interface scq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [scq_pkg::CFG_IDX_W-1:0]   index;
  logic [scq_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/three_class_server_scheduler_core.sv =====
// Arrival, completion and rejected requests register their result in the cycle after accept.
// A grant or an aging promotion goes through state S_READ for the registered read of the shared
//   queue RAM before its result is registered.
// One request at a time: no new one is taken in S_READ or while a result waits on the output.
// Reset: clears pointers, counts, streaks, slot state; sets defaults (free slots 2, next id 1);
//   the queue RAM is not cleared, its entries are read only after being written.
module three_class_server_scheduler_core #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int SERVER_COUNT = 4,
  parameter int ID_BITS      = 16
) (
  input logic         clk,
  input logic         rst,
  scq_in_if.sink      req,
  scq_out_if.source   rsp,
  scq_cfg_if.sink     cfg
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = scq_pkg::NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(RAM_DEPTH);
  localparam int SUM_W   = $clog2(RAM_DEPTH + 1);
  localparam int TOT_W   = (SUM_W > scq_pkg::TOTAL_W) ? SUM_W : scq_pkg::TOTAL_W;
  localparam int CMP_W   = (CNT_W > scq_pkg::THR_W) ? CNT_W : scq_pkg::THR_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ram_addr(input logic [scq_pkg::CLASS_W-1:0] c,
                                                  input logic [PTR_W-1:0] p);
    ram_addr = ADDR_W'(int'(c) * QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  scq_pkg::state_t state, state_next;

  logic [PTR_W-1:0] head [scq_pkg::NUM_CLASSES];
  logic [PTR_W-1:0] head_next [scq_pkg::NUM_CLASSES];
  logic [PTR_W-1:0] tail [scq_pkg::NUM_CLASSES];
  logic [PTR_W-1:0] tail_next [scq_pkg::NUM_CLASSES];
  logic [CNT_W-1:0] count [scq_pkg::NUM_CLASSES];
  logic [CNT_W-1:0] count_next [scq_pkg::NUM_CLASSES];
  logic [scq_pkg::STREAK_W-1:0] streak [scq_pkg::SERVER_SLOTS];
  logic [scq_pkg::STREAK_W-1:0] streak_next [scq_pkg::SERVER_SLOTS];
  logic [scq_pkg::SERVER_SLOTS-1:0] serving, serving_next;
  logic [scq_pkg::CAP_W-1:0] free_slots, free_slots_next;
  logic [ID_BITS-1:0] id_ctr, id_ctr_next, id_inc;

  logic [scq_pkg::STREAK_W-1:0] streak_limit;
  logic [scq_pkg::THR_W-1:0]    aging_threshold;
  logic [scq_pkg::MASK_W-1:0]   senior_mask;
  logic [scq_pkg::CAP_W-1:0]    senior_capacity;

  logic                           pend_tick, pend_tick_next;
  logic [scq_pkg::CLASS_W-1:0]    pend_class, pend_class_next;
  logic [ADDR_W-1:0]              pend_waddr, pend_waddr_next;

  logic                           rsp_valid, rsp_valid_next;
  scq_pkg::status_t               rsp_status, rsp_status_next;
  logic [ID_BITS-1:0]             rsp_id, rsp_id_next;
  logic [scq_pkg::CLASS_W-1:0]    rsp_class, rsp_class_next;
  logic [TOT_W-1:0]               rsp_total, rsp_total_next;

  logic                           mem_we, mem_re;
  logic [ADDR_W-1:0]              mem_waddr, mem_raddr;
  logic [ID_BITS-1:0]             mem_wdata, mem_rdata;

  logic                           req_acc, cfg_acc, srv_ok, senior, crit_ok, take_ok;
  logic [scq_pkg::CLASS_W-1:0]    take_c, cls;
  logic [scq_pkg::SRV_W-1:0]      srv;
  logic [TOT_W-1:0]               total_sum;

  scq_queue_ram #(
    .DEPTH  (RAM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ID_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready  = (state == scq_pkg::S_IDLE) && (!rsp_valid || rsp.ready);
  assign req_acc    = req.valid && req.ready;
  assign cfg.ready  = 1'b1;
  assign cfg_acc    = cfg.valid;

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.item_id       = rsp_id;
  assign rsp.item_class    = rsp_class;
  assign rsp.waiting_total = rsp_total[scq_pkg::TOTAL_W-1:0];

  assign cls    = req.arrival_class;
  assign srv    = req.server_index;
  assign srv_ok = int'(srv) < SERVER_COUNT;
  assign senior = senior_mask[srv];
  assign crit_ok = senior && (free_slots != '0) && !serving[srv];
  assign id_inc = id_ctr + 1'b1;

  always_comb begin
    take_ok = 1'b1;
    take_c  = scq_pkg::CLS_NORMAL;
    if ((streak[srv] >= streak_limit) && (count[scq_pkg::CLS_SERIOUS] != '0)) begin
      take_c = scq_pkg::CLS_SERIOUS;
    end else if (crit_ok && (count[scq_pkg::CLS_CRITICAL] != '0)) begin
      take_c = scq_pkg::CLS_CRITICAL;
    end else if (count[scq_pkg::CLS_SERIOUS] != '0) begin
      take_c = scq_pkg::CLS_SERIOUS;
    end else if (count[scq_pkg::CLS_NORMAL] != '0) begin
      take_c = scq_pkg::CLS_NORMAL;
    end else begin
      take_ok = 1'b0;
    end
  end

  assign total_sum = TOT_W'(count_next[0]) + TOT_W'(count_next[1]) + TOT_W'(count_next[2]);

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    streak_next     = streak;
    serving_next    = serving;
    free_slots_next = free_slots;
    id_ctr_next     = id_ctr;
    pend_tick_next  = pend_tick;
    pend_class_next = pend_class;
    pend_waddr_next = pend_waddr;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_status_next = rsp_status;
    rsp_id_next     = rsp_id;
    rsp_class_next  = rsp_class;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;

    case (state)
      scq_pkg::S_IDLE: begin
        if (req_acc) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = scq_pkg::ST_NONE;
          rsp_id_next     = '0;
          rsp_class_next  = scq_pkg::CLS_NORMAL;
          case (scq_pkg::mode_t'(req.mode))
            scq_pkg::MODE_ARRIVAL: begin
              if (cls == scq_pkg::CLS_INVALID) begin
                rsp_status_next = scq_pkg::ST_NONE;
              end else if (cls == scq_pkg::CLS_CRITICAL && free_slots == '0) begin
                rsp_status_next = scq_pkg::ST_HELD;
              end else if (count[cls] >= CNT_FULL) begin
                rsp_status_next = scq_pkg::ST_FULL;
                rsp_class_next  = cls;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = ram_addr(cls, tail[cls]);
                mem_wdata       = id_ctr;
                tail_next[cls]  = ptr_inc(tail[cls]);
                count_next[cls] = count[cls] + 1'b1;
                id_ctr_next     = (id_inc == '0) ? ID_BITS'(1) : id_inc;
                rsp_status_next = scq_pkg::ST_DONE;
                rsp_id_next     = id_ctr;
                rsp_class_next  = cls;
              end
            end
            scq_pkg::MODE_REQUEST: begin
              if (srv_ok && take_ok) begin
                rsp_valid_next     = 1'b0;
                mem_re             = 1'b1;
                mem_raddr          = ram_addr(take_c, head[take_c]);
                head_next[take_c]  = ptr_inc(head[take_c]);
                count_next[take_c] = count[take_c] - 1'b1;
                if (take_c == scq_pkg::CLS_NORMAL) begin
                  if (streak[srv] < streak_limit) begin
                    streak_next[srv] = streak[srv] + 1'b1;
                  end
                end else begin
                  streak_next[srv] = '0;
                end
                if (take_c == scq_pkg::CLS_CRITICAL) begin
                  free_slots_next = free_slots - 1'b1;
                  serving_next[srv] = 1'b1;
                end
                pend_tick_next  = 1'b0;
                pend_class_next = take_c;
                state_next      = scq_pkg::S_READ;
              end
            end
            scq_pkg::MODE_COMPLETE: begin
              if (srv_ok && serving[srv]) begin
                serving_next[srv] = 1'b0;
                if (free_slots < senior_capacity) begin
                  free_slots_next = free_slots + 1'b1;
                end
                rsp_status_next = scq_pkg::ST_DONE;
                rsp_class_next  = scq_pkg::CLS_CRITICAL;
              end
            end
            scq_pkg::MODE_TICK: begin
              if ((count[scq_pkg::CLS_SERIOUS] != '0) &&
                  (CMP_W'(count[scq_pkg::CLS_SERIOUS]) >= CMP_W'(aging_threshold))) begin
                if (count[scq_pkg::CLS_CRITICAL] >= CNT_FULL) begin
                  rsp_status_next = scq_pkg::ST_FULL;
                end else begin
                  rsp_valid_next = 1'b0;
                  mem_re         = 1'b1;
                  mem_raddr      = ram_addr(scq_pkg::CLS_SERIOUS, head[scq_pkg::CLS_SERIOUS]);
                  head_next[scq_pkg::CLS_SERIOUS]  = ptr_inc(head[scq_pkg::CLS_SERIOUS]);
                  count_next[scq_pkg::CLS_SERIOUS] = count[scq_pkg::CLS_SERIOUS] - 1'b1;
                  tail_next[scq_pkg::CLS_CRITICAL] = ptr_inc(tail[scq_pkg::CLS_CRITICAL]);
                  count_next[scq_pkg::CLS_CRITICAL] = count[scq_pkg::CLS_CRITICAL] + 1'b1;
                  pend_tick_next  = 1'b1;
                  pend_class_next = scq_pkg::CLS_CRITICAL;
                  pend_waddr_next = ram_addr(scq_pkg::CLS_CRITICAL,
                                             tail[scq_pkg::CLS_CRITICAL]);
                  state_next      = scq_pkg::S_READ;
                end
              end
            end
            default: begin
              rsp_status_next = scq_pkg::ST_NONE;
            end
          endcase
        end
      end
      scq_pkg::S_READ: begin
        if (pend_tick) begin
          mem_we    = 1'b1;
          mem_waddr = pend_waddr;
          mem_wdata = mem_rdata;
        end
        rsp_valid_next  = 1'b1;
        rsp_status_next = scq_pkg::ST_DONE;
        rsp_id_next     = mem_rdata;
        rsp_class_next  = pend_class;
        state_next      = scq_pkg::S_IDLE;
      end
      default: begin
        state_next = scq_pkg::S_IDLE;
      end
    endcase

    // capacity write reloads the free slots
    if (cfg_acc && cfg.index == scq_pkg::REG_SENIOR_CAP) begin
      free_slots_next = cfg.data[scq_pkg::CAP_W-1:0];
    end
  end

  assign rsp_total_next = total_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= scq_pkg::S_IDLE;
      rsp_valid       <= 1'b0;
      serving         <= '0;
      free_slots      <= scq_pkg::CAP_RST;
      id_ctr          <= ID_BITS'(1);
      streak_limit    <= scq_pkg::STREAK_RST;
      aging_threshold <= scq_pkg::THR_RST;
      senior_mask     <= scq_pkg::MASK_RST;
      senior_capacity <= scq_pkg::CAP_RST;
      for (int i = 0; i < scq_pkg::NUM_CLASSES; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
      for (int i = 0; i < scq_pkg::SERVER_SLOTS; i++) begin
        streak[i] <= '0;
      end
    end else begin
      state      <= state_next;
      rsp_valid  <= rsp_valid_next;
      serving    <= serving_next;
      free_slots <= free_slots_next;
      id_ctr     <= id_ctr_next;
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      streak     <= streak_next;
      if (cfg_acc) begin
        case (scq_pkg::reg_idx_t'(cfg.index))
          scq_pkg::REG_STREAK_LIMIT: streak_limit    <= cfg.data[scq_pkg::STREAK_W-1:0];
          scq_pkg::REG_AGING_THR:    aging_threshold <= cfg.data;
          scq_pkg::REG_SENIOR_MASK:  senior_mask     <= cfg.data[scq_pkg::MASK_W-1:0];
          scq_pkg::REG_SENIOR_CAP:   senior_capacity <= cfg.data[scq_pkg::CAP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_tick  <= pend_tick_next;
    pend_class <= pend_class_next;
    pend_waddr <= pend_waddr_next;
    if (rsp_valid_next && !(rsp_valid && !rsp.ready)) begin
      rsp_status <= rsp_status_next;
      rsp_id     <= rsp_id_next;
      rsp_class  <= rsp_class_next;
      rsp_total  <= rsp_total_next;
    end
  end

endmodule

// ===== rtl/scq_queue_ram.sv =====
module scq_queue_ram #(
  parameter int DEPTH  = 48,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/scq_checker.sv =====
`include "three_class_server_scheduler_core_assert.svh"

module scq_checker #(
  parameter int ID_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [scq_pkg::STATUS_W-1:0]  rsp_status,
  input logic [ID_BITS-1:0]            rsp_item_id,
  input logic [scq_pkg::CLASS_W-1:0]   rsp_item_class
);

  `SCQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item_id) && $stable(rsp_status), "result changed while stalled")
  `SCQ_ASSERT_NOW(a_no_id_on_fail, rsp_valid && (rsp_status != scq_pkg::ST_DONE), rsp_item_id == '0, "failed request carries an id")
  `SCQ_ASSERT_NOW(a_none_no_class, rsp_valid && (rsp_status == scq_pkg::ST_NONE || rsp_status == scq_pkg::ST_HELD), rsp_item_class == scq_pkg::CLS_NORMAL, "idle result carries a class")
  `SCQ_ASSERT_NOW(a_rsp_has_cause, $rose(rsp_valid), $past(req_valid && req_ready) || $past(req_valid && req_ready, 2), "result without request")

endmodule

bind three_class_server_scheduler_core scq_checker #(
  .ID_BITS (ID_BITS)
) u_scq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_item_id    (rsp.item_id),
  .rsp_item_class (rsp.item_class)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import scq_pkg::*;

  localparam int LANE_DEPTH      = 16;
  localparam int WATCHDOG_CYCLES = 2000;

  typedef struct packed {
    status_t              status;
    logic [15:0]          id;
    logic [CLASS_W-1:0]   cls;
    logic [TOTAL_W-1:0]   total;
  } outcome_t;

  class dispatch_ledger;
    logic [15:0]          lane [NUM_CLASSES][$];
    bit [STREAK_W-1:0]    streak [SERVER_SLOTS];
    bit                   busy_crit [SERVER_SLOTS];
    logic [CAP_W-1:0]     free_slots = CAP_RST;
    logic [15:0]          next_id = 16'd1;
    logic [STREAK_W-1:0]  streak_limit = STREAK_RST;
    logic [THR_W-1:0]     aging_thr = THR_RST;
    logic [MASK_W-1:0]    senior_mask = MASK_RST;
    logic [CAP_W-1:0]     senior_cap = CAP_RST;
    outcome_t             outcomes_due [$];
    int                   errors = 0;

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_STREAK_LIMIT: streak_limit = d[STREAK_W-1:0];
        REG_AGING_THR:    aging_thr = d[THR_W-1:0];
        REG_SENIOR_MASK:  senior_mask = d[MASK_W-1:0];
        default: begin
          senior_cap = d[CAP_W-1:0];
          free_slots = d[CAP_W-1:0];
        end
      endcase
    endfunction

    function void log_request(mode_t m, logic [CLASS_W-1:0] cls, logic [SRV_W-1:0] srv);
      outcome_t           o;
      logic [CLASS_W-1:0] take;
      bit                 found;
      bit                 crit_ok;
      o = '{status: ST_NONE, id: '0, cls: CLS_NORMAL, total: '0};
      take = CLS_NORMAL;
      case (m)
        MODE_ARRIVAL: begin
          if (cls != CLS_INVALID) begin
            if (cls == CLS_CRITICAL && free_slots == 0) begin
              o.status = ST_HELD;
            end else if (lane[cls].size() >= LANE_DEPTH) begin
              o.status = ST_FULL;
              o.cls = cls;
            end else begin
              o.status = ST_DONE;
              o.id = next_id;
              o.cls = cls;
              lane[cls].push_back(next_id);
              next_id = next_id + 16'd1;
              if (next_id == 16'd0) next_id = 16'd1;
            end
          end
        end
        MODE_REQUEST: begin
          crit_ok = senior_mask[srv] && free_slots != 0 && !busy_crit[srv];
          found = 1'b1;
          if (streak[srv] >= streak_limit && lane[CLS_SERIOUS].size() != 0) take = CLS_SERIOUS;
          else if (crit_ok && lane[CLS_CRITICAL].size() != 0) take = CLS_CRITICAL;
          else if (lane[CLS_SERIOUS].size() != 0) take = CLS_SERIOUS;
          else if (lane[CLS_NORMAL].size() != 0) take = CLS_NORMAL;
          else found = 1'b0;
          if (found) begin
            o.status = ST_DONE;
            o.cls = take;
            o.id = lane[take].pop_front();
            if (take == CLS_NORMAL) begin
              if (streak[srv] < streak_limit) streak[srv] = streak[srv] + 1'b1;
            end else begin
              streak[srv] = '0;
            end
            if (take == CLS_CRITICAL) begin
              free_slots = free_slots - 1'b1;
              busy_crit[srv] = 1'b1;
            end
          end
        end
        MODE_COMPLETE: begin
          if (busy_crit[srv]) begin
            busy_crit[srv] = 1'b0;
            if (free_slots < senior_cap) free_slots = free_slots + 1'b1;
            o.status = ST_DONE;
            o.cls = CLS_CRITICAL;
          end
        end
        default: begin
          if (lane[CLS_SERIOUS].size() != 0 && lane[CLS_SERIOUS].size() >= aging_thr) begin
            if (lane[CLS_CRITICAL].size() >= LANE_DEPTH) begin
              o.status = ST_FULL;
            end else begin
              o.id = lane[CLS_SERIOUS].pop_front();
              lane[CLS_CRITICAL].push_back(o.id);
              o.status = ST_DONE;
              o.cls = CLS_CRITICAL;
            end
          end
        end
      endcase
      o.total = TOTAL_W'(lane[CLS_NORMAL].size() + lane[CLS_SERIOUS].size()
                         + lane[CLS_CRITICAL].size());
      outcomes_due.push_back(o);
    endfunction

    function void match_outcome(logic [STATUS_W-1:0] st, logic [15:0] id,
                                logic [CLASS_W-1:0] cls, logic [TOTAL_W-1:0] total);
      outcome_t w;
      if (outcomes_due.size() == 0) begin
        $error("result with no request pending: status %0d item_id %0d", st, id);
        errors++;
      end else begin
        w = outcomes_due.pop_front();
        if (st !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, st);
          errors++;
        end
        if (id !== w.id) begin
          $error("item_id: expected %0d, got %0d", w.id, id);
          errors++;
        end
        if (cls !== w.cls) begin
          $error("item_class: expected %0d, got %0d", w.cls, cls);
          errors++;
        end
        if (total !== w.total) begin
          $error("waiting_total: expected %0d, got %0d", w.total, total);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  scq_in_if                 req_if ();
  scq_out_if #(.ID_BITS(16)) rsp_if ();
  scq_cfg_if                cfg_if ();

  three_class_server_scheduler_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  dispatch_ledger book = new;
  bit idle_on = 1'b1;
  bit calm    = 1'b0;
  int hold_len   = 0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off on demand
  always @(negedge clk) begin
    if (hold_len != 0) begin
      rsp_if.ready = 1'b0;
      hold_len--;
    end else if (stall_left != 0) begin
      rsp_if.ready = 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready = 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      book.match_outcome(rsp_if.status, rsp_if.item_id, rsp_if.item_class, rsp_if.waiting_total);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic put_req(mode_t m, logic [CLASS_W-1:0] c, logic [SRV_W-1:0] s);
    req_if.valid = 1'b1;
    req_if.mode = m;
    req_if.arrival_class = c;
    req_if.server_index = s;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    book.log_request(m, c, s);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // sender stops until every result is back; block is idle afterwards
  task automatic settle();
    req_if.valid = 1'b0;
    while (book.outcomes_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    book.write_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] lim, logic [CFG_DATA_W-1:0] thr,
                            logic [CFG_DATA_W-1:0] mask, logic [CFG_DATA_W-1:0] cap);
    settle();
    put_reg(REG_STREAK_LIMIT, lim);
    put_reg(REG_AGING_THR, thr);
    put_reg(REG_SENIOR_MASK, mask);
    put_reg(REG_SENIOR_CAP, cap);
    cfg_if.valid = 1'b0;
  endtask

  task automatic random_run(int n, int w_arr, int w_req, int w_cmp);
    int                 r;
    logic [CLASS_W-1:0] c;
    for (int i = 0; i < n; i++) begin
      idle_on = !calm && (i % 100) < 70;
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 15) == 0) ? CLS_INVALID : CLASS_W'($urandom_range(0, 2));
      if (r < w_arr) put_req(MODE_ARRIVAL, c, SRV_W'($urandom));
      else if (r < w_arr + w_req) put_req(MODE_REQUEST, c, SRV_W'($urandom));
      else if (r < w_arr + w_req + w_cmp) put_req(MODE_COMPLETE, c, SRV_W'($urandom));
      else put_req(MODE_TICK, c, SRV_W'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.mode = MODE_ARRIVAL;
    req_if.arrival_class = CLS_NORMAL;
    req_if.server_index = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_STREAK_LIMIT;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: servers 0 and 1 senior, two slots, streak 3
    put_req(MODE_REQUEST, CLS_NORMAL, 2'd0);
    put_req(MODE_COMPLETE, CLS_NORMAL, 2'd2);
    put_req(MODE_TICK, CLS_NORMAL, 2'd3);
    put_req(MODE_ARRIVAL, CLS_INVALID, 2'd0);
    put_req(MODE_ARRIVAL, CLS_NORMAL, 2'd0);
    put_req(MODE_ARRIVAL, CLS_SERIOUS, 2'd1);
    put_req(MODE_ARRIVAL, CLS_CRITICAL, 2'd2);
    put_req(MODE_ARRIVAL, CLS_CRITICAL, 2'd3);
    put_req(MODE_REQUEST, CLS_NORMAL, 2'd2);
    put_req(MODE_REQUEST, CLS_NORMAL, 2'd0);
    put_req(MODE_REQUEST, CLS_NORMAL, 2'd0);
    put_req(MODE_REQUEST, CLS_NORMAL, 2'd1);
    put_req(MODE_ARRIVAL, CLS_CRITICAL, 2'd3);
    put_req(MODE_COMPLETE, CLS_NORMAL, 2'd0);
    put_req(MODE_COMPLETE, CLS_NORMAL, 2'd0);
    put_req(MODE_ARRIVAL, CLS_CRITICAL, 2'd0);
    put_req(MODE_REQUEST, CLS_NORMAL, 2'd0);
    repeat (3) put_req(MODE_ARRIVAL, CLS_NORMAL, 2'd0);
    repeat (3) put_req(MODE_REQUEST, CLS_NORMAL, 2'd0);
    put_req(MODE_ARRIVAL, CLS_SERIOUS, 2'd0);
    put_req(MODE_COMPLETE, CLS_NORMAL, 2'd0);
    put_req(MODE_ARRIVAL, CLS_CRITICAL, 2'd0);
    put_req(MODE_REQUEST, CLS_NORMAL, 2'd0);

    set_config(5'd3, 5'd5, 5'd3, 5'd2);
    random_run(125, 40, 40, 10);
    settle();
    random_run(125, 40, 40, 10);

    set_config(5'd1, 5'd1, 5'd15, 5'd4);
    random_run(100, 60, 20, 5);
    hold_len = 80;
    random_run(150, 60, 20, 5);

    set_config(5'd2, 5'd16, 5'd0, 5'd0);
    random_run(250, 35, 50, 10);

    set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
               CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    random_run(250, 40, 40, 10);

    calm = 1'b1;
    idle_on = 1'b0;

    set_config(5'd1, 5'd2, 5'd15, 5'd1);
    random_run(200, 40, 40, 10);

    req_if.valid = 1'b0;
    while (book.outcomes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
